@@ src/ntsa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntsa_pkg: shared types for the nearest-timestamp sample aligner
// Request/response items, stored sample, match control and scan states.
// ----------------------------------------------------------------------------
package ntsa_pkg;

   localparam int STAMP_W = 63;
   localparam int ANGLE_W = 32;
   localparam int OFFS_W  = 64;
   localparam int SKEW_W  = 32;

   localparam logic CMD_PUSH  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam int  CSR_ADDR_W      = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_WARN_SKEW = 3'd0;
   localparam logic [SKEW_W-1:0]     SKEW_RESET    = 32'd50000000;

   typedef struct packed {
      logic                       cmd;
      logic [STAMP_W-1:0]         stamp_ns;
      logic signed [ANGLE_W-1:0]  yaw_in;
      logic signed [ANGLE_W-1:0]  pitch_in;
   } req_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0]  yaw_out;
      logic signed [ANGLE_W-1:0]  pitch_out;
      logic signed [OFFS_W-1:0]   offset_ns;
      logic                       empty_flag;
      logic                       late_flag;
   } rsp_type;

   typedef struct packed {
      logic [STAMP_W-1:0]         stamp;
      logic signed [ANGLE_W-1:0]  yaw;
      logic signed [ANGLE_W-1:0]  pitch;
   } sample_type;

   typedef struct packed {
      logic clear;
      logic valid;
   } match_ctl_type;

   typedef struct packed {
      logic                       found;
      logic [STAMP_W-1:0]         gap;
      logic signed [OFFS_W-1:0]   diff;
      logic signed [ANGLE_W-1:0]  yaw;
      logic signed [ANGLE_W-1:0]  pitch;
   } match_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

endpackage

@@ src/ntsa_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntsa_cell: one history cell
// Holds one timestamped sample and takes its left neighbor's sample on shift.
// ----------------------------------------------------------------------------
module ntsa_cell (
   input  logic                  clock,
   input  logic                  shift_en,
   input  ntsa_pkg::sample_type  left_sample,
   output ntsa_pkg::sample_type  cell_sample
);
   import ntsa_pkg::*;

   sample_type sample_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         sample_ff <= left_sample;
      end
   end

   assign cell_sample = sample_ff;

endmodule

@@ src/ntsa_match.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntsa_match: nearest-sample tracker
// Two stages: absolute gap and signed offset, then keep the strictly closer one.
// ----------------------------------------------------------------------------
module ntsa_match (
   input  logic                          clock,
   input  logic                          reset,
   input  ntsa_pkg::match_ctl_type       ctl,
   input  ntsa_pkg::sample_type          sample,
   input  logic [ntsa_pkg::STAMP_W-1:0]  query_time,
   output ntsa_pkg::match_type           best
);
   import ntsa_pkg::*;

   logic [OFFS_W-1:0]   fwd_diff;
   logic [OFFS_W-1:0]   rev_diff;
   logic                s1_valid_ff;
   logic [STAMP_W-1:0]  s1_gap_ff;
   logic [OFFS_W-1:0]   s1_diff_ff;
   logic [ANGLE_W-1:0]  s1_yaw_ff;
   logic [ANGLE_W-1:0]  s1_pitch_ff;
   logic                take;
   match_type           best_ff;

   // both directions in parallel, pick by sign
   assign fwd_diff = {1'b0, sample.stamp} - {1'b0, query_time};
   assign rev_diff = {1'b0, query_time} - {1'b0, sample.stamp};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.valid) begin
         s1_gap_ff   <= fwd_diff[OFFS_W-1] ? rev_diff[STAMP_W-1:0] : fwd_diff[STAMP_W-1:0];
         s1_diff_ff  <= fwd_diff;
         s1_yaw_ff   <= sample.yaw;
         s1_pitch_ff <= sample.pitch;
      end
   end

   // strict compare: on a tie keep the older sample
   assign take = s1_valid_ff && (!best_ff.found || (s1_gap_ff < best_ff.gap));

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         best_ff.found <= 1'b0;
      end else if (take) begin
         best_ff.found <= 1'b1;
      end
      if (take) begin
         best_ff.gap   <= s1_gap_ff;
         best_ff.diff  <= s1_diff_ff;
         best_ff.yaw   <= s1_yaw_ff;
         best_ff.pitch <= s1_pitch_ff;
      end
   end

   assign best = best_ff;

endmodule

@@ src/nearest_timestamp_sample_align.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_timestamp_sample_align: nearest-timestamp gimbal sample lookup
// Sample history in a shift chain, rotating scan for the closest timestamp.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one item per handshake: cmd 0 pushes a sample
//   (time, yaw, pitch), cmd 1 queries by image time. rsp_ returns one item
//   per query and none per push. The APB port holds warn_skew_ns at address 0.
//   The history is a chain of DEPTH cells; a push shifts a new sample in and
//   drops the oldest when full. A query rotates the whole chain once
//   through the match unit at its end, one cell per cycle, then passes the
//   drain and finish states and loads the result into the output register
//   (from idle straight to finish when the history is empty); the request
//   side is busy until then. The chain rotation sets the rate.
//   A finished result waits in the output register while the receiver
//   stalls; pushes are still accepted, and a new query scans but holds its
//   result until the register frees up.
//   Reset empties the history and restores warn_skew_ns to 50000000.
// ----------------------------------------------------------------------------
module nearest_timestamp_sample_align #(
   parameter int DEPTH = 50
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  ntsa_pkg::req_type                 req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output ntsa_pkg::rsp_type                 rsp_payload,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ntsa_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   import ntsa_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] LAST_C  = CNT_W'(DEPTH - 1);

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [CNT_W-1:0]    scan_ff, scan_in;
   logic [STAMP_W-1:0]  query_stamp_ff;
   logic [SKEW_W-1:0]   warn_skew_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff;
   rsp_type             rsp_data_in;

   logic                req_fire;
   logic                push_fire;
   logic                query_fire;
   logic                shift_en;
   logic                rsp_load;
   sample_type          chain_src;
   sample_type          cell_q [DEPTH];
   match_ctl_type       match_ctl;
   match_type           best;

   // ---------------- configuration port ----------------
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         warn_skew_ff <= SKEW_RESET;
      end else if (psel && penable && pwrite && (paddr == CSR_WARN_SKEW)) begin
         warn_skew_ff <= pwdata;
      end
   end

   assign prdata = (paddr == CSR_WARN_SKEW) ? warn_skew_ff : 32'd0;

   // ---------------- handshake ----------------
   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign push_fire  = req_fire && (req_payload.cmd == CMD_PUSH);
   assign query_fire = req_fire && (req_payload.cmd == CMD_QUERY);

   // ---------------- sample chain ----------------
   // recirculate the oldest end into the newest end while scanning
   assign shift_en  = push_fire || (state_ff == ST_SCAN);
   assign chain_src = (state_ff == ST_SCAN) ? cell_q[DEPTH-1] :
                      sample_type'{stamp: req_payload.stamp_ns,
                                   yaw:   req_payload.yaw_in,
                                   pitch: req_payload.pitch_in};

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_head
         ntsa_cell u_cell (
            .clock       (clock),
            .shift_en    (shift_en),
            .left_sample (chain_src),
            .cell_sample (cell_q[g])
         );
      end else begin : g_body
         ntsa_cell u_cell (
            .clock       (clock),
            .shift_en    (shift_en),
            .left_sample (cell_q[g-1]),
            .cell_sample (cell_q[g])
         );
      end
   end

   // ---------------- match unit ----------------
   // occupied cells leave the chain end in the last fill_ff scan steps, oldest first
   assign match_ctl.clear = query_fire;
   assign match_ctl.valid = (state_ff == ST_SCAN) && (scan_ff >= (DEPTH_C - fill_ff));

   ntsa_match u_match (
      .clock       (clock),
      .reset       (reset),
      .ctl         (match_ctl),
      .sample      (cell_q[DEPTH-1]),
      .query_time  (query_stamp_ff),
      .best        (best)
   );

   always_ff @(posedge clock) begin
      if (query_fire) begin
         query_stamp_ff <= req_payload.stamp_ns;
      end
   end

   // ---------------- control ----------------
   always_comb begin
      state_in = state_ff;
      scan_in  = scan_ff;
      fill_in  = fill_ff;
      rsp_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            scan_in = '0;
            if (push_fire && (fill_ff != DEPTH_C)) begin
               fill_in = fill_ff + 1'b1;
            end
            if (query_fire) begin
               state_in = (fill_ff == '0) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            scan_in = scan_ff + 1'b1;
            if (scan_ff == LAST_C) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         scan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         scan_ff  <= scan_in;
      end
   end

   // ---------------- result register ----------------
   always_comb begin
      rsp_data_in.yaw_out    = best.found ? best.yaw   : '0;
      rsp_data_in.pitch_out  = best.found ? best.pitch : '0;
      rsp_data_in.offset_ns  = best.found ? best.diff  : '0;
      rsp_data_in.empty_flag = !best.found;
      rsp_data_in.late_flag  = best.found &&
                               (best.gap > {{(STAMP_W-SKEW_W){1'b0}}, warn_skew_ff});
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // ---------------- assertions ----------------
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= DEPTH_C)
      else $error("fill count above history depth");

   a_full_push_holds: assert property (@(posedge clock) disable iff (reset)
      (push_fire && (fill_ff == DEPTH_C)) |=> (fill_ff == DEPTH_C))
      else $error("fill count changed on push into full history");

   a_empty_query_skips_scan: assert property (@(posedge clock) disable iff (reset)
      (query_fire && (fill_ff == '0)) |=> (state_ff == ST_FINISH))
      else $error("empty query did not go straight to finish");

   a_scan_full_turn: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && (scan_ff == LAST_C) |=> (state_ff == ST_DRAIN))
      else $error("scan did not end after one full chain rotation");

   a_load_only_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while held");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for nearest_timestamp_sample_align
// Pushes timestamped gimbal samples and queries by image time over the
// req/rsp handshakes. A local copy of the sample history predicts each
// match (nearest time, older sample on a tie, late flag against the skew
// register). Both sides idle at random outside the quiet phase. The skew
// register is rewritten between traffic phases over the APB port and read back.
// ----------------------------------------------------------------------------
module testbench;
   import ntsa_pkg::*;

   localparam int HIST_DEPTH = 50;
   localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_type         req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_type         rsp_payload;
   logic            psel;
   logic            penable;
   logic            pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]     pwdata;
   logic [31:0]     prdata;
   logic            pready;

   // local copy of the sample history
   logic [STAMP_W-1:0] hist_time  [HIST_DEPTH];
   logic [ANGLE_W-1:0] hist_yaw   [HIST_DEPTH];
   logic [ANGLE_W-1:0] hist_pitch [HIST_DEPTH];
   int                 hist_head;
   int                 hist_count;
   logic [SKEW_W-1:0]  skew_ns;
   logic [STAMP_W-1:0] push_base;

   rsp_type expected_matches[$];
   int      mismatch_count;
   bit      no_idle;

   nearest_timestamp_sample_align #(
      .DEPTH(HIST_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   always @(negedge clock) begin
      rsp_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 8);
   end

   // ---------------------------------------------------------------- model
   function automatic void record_sample(input req_type item);
      int slot;
      if (hist_count < HIST_DEPTH) begin
         slot = (hist_head + hist_count) % HIST_DEPTH;
         hist_count++;
      end else begin
         // full: overwrite the oldest and advance
         slot = hist_head;
         hist_head = (hist_head + 1) % HIST_DEPTH;
      end
      hist_time[slot]  = item.stamp_ns;
      hist_yaw[slot]   = item.yaw_in;
      hist_pitch[slot] = item.pitch_in;
   endfunction

   function automatic rsp_type match_nearest(input logic [STAMP_W-1:0] query_stamp);
      rsp_type            m;
      int                 slot;
      int                 best;
      logic [STAMP_W-1:0] gap;
      logic [STAMP_W-1:0] best_gap;
      m = '0;
      best = hist_head;
      best_gap = '0;
      if (hist_count == 0) begin
         m.empty_flag = 1'b1;
         return m;
      end
      for (int i = 0; i < hist_count; i++) begin
         slot = (hist_head + i) % HIST_DEPTH;
         gap = (hist_time[slot] >= query_stamp) ? hist_time[slot] - query_stamp
                                                : query_stamp - hist_time[slot];
         // strict compare keeps the older sample on a tie
         if (i == 0 || gap < best_gap) begin
            best_gap = gap;
            best = slot;
         end
      end
      m.yaw_out   = hist_yaw[best];
      m.pitch_out = hist_pitch[best];
      m.offset_ns = {1'b0, hist_time[best]} - {1'b0, query_stamp};
      m.late_flag = ({1'b0, best_gap} > {32'd0, skew_ns});
      return m;
   endfunction

   // ------------------------------------------------------------- checking
   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t mismatch %s: expected %h actual %h", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_matches.size() == 0) begin
            $display("%0t unexpected result item: expected none actual %h",
                     $time, rsp_payload);
            mismatch_count++;
         end else begin
            want = expected_matches[0];
            expected_matches.delete(0);
            check_field("yaw_out", want.yaw_out, rsp_payload.yaw_out);
            check_field("pitch_out", want.pitch_out, rsp_payload.pitch_out);
            check_field("offset_ns", want.offset_ns, rsp_payload.offset_ns);
            check_field("empty_flag", want.empty_flag, rsp_payload.empty_flag);
            check_field("late_flag", want.late_flag, rsp_payload.late_flag);
         end
      end
   end

   // -------------------------------------------------------------- drivers
   task automatic send_item(input req_type item);
      while (!no_idle && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (item.cmd == CMD_PUSH) record_sample(item);
      else expected_matches.insert(expected_matches.size(), match_nearest(item.stamp_ns));
      @(negedge clock);
   endtask

   task automatic push_sample(input logic [STAMP_W-1:0] stamp,
                              input logic [ANGLE_W-1:0] yaw,
                              input logic [ANGLE_W-1:0] pitch);
      req_type item;
      item.cmd      = CMD_PUSH;
      item.stamp_ns = stamp;
      item.yaw_in   = yaw;
      item.pitch_in = pitch;
      send_item(item);
   endtask

   task automatic query_at(input logic [STAMP_W-1:0] stamp);
      req_type item;
      item.cmd      = CMD_QUERY;
      item.stamp_ns = stamp;
      item.yaw_in   = $urandom;
      item.pitch_in = $urandom;
      send_item(item);
   endtask

   // hold the sender off until every match has come back
   task automatic wait_results_done(input int extra);
      req_valid <= 1'b0;
      while (expected_matches.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_warn_skew(input logic [SKEW_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_WARN_SKEW;
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      skew_ns = value;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      check_field("warn_skew_ns readback", value, prdata);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // ------------------------------------------------------------- stimulus
   function automatic logic [STAMP_W-1:0] random_stamp();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[STAMP_W-1:0];
   endfunction

   function automatic logic [STAMP_W-1:0] stored_stamp();
      return hist_time[(hist_head + $urandom_range(hist_count - 1)) % HIST_DEPTH];
   endfunction

   function automatic logic [63:0] skew_delta();
      case ($urandom_range(3))
         0: return 64'd0;
         1: return {32'd0, skew_ns};
         2: return {32'd0, skew_ns} + 64'd1;
         default: return {32'd0, $urandom_range(skew_ns)} + {32'd0, $urandom_range(skew_ns)};
      endcase
   endfunction

   // move a time by delta in a random direction, staying inside 63 bits
   function automatic logic [STAMP_W-1:0] shift_stamp(input logic [STAMP_W-1:0] t,
                                                     input logic [63:0] delta);
      logic [63:0] sum;
      sum = {1'b0, t} + delta;
      if ($urandom_range(1) == 0 && {1'b0, t} >= delta) return t - delta[STAMP_W-1:0];
      else if (!sum[63]) return sum[STAMP_W-1:0];
      else return t;
   endfunction

   function automatic req_type make_random_item();
      req_type     item;
      logic [63:0] mid;
      int          pick;
      item.yaw_in   = $urandom;
      item.pitch_in = $urandom;
      if ($urandom_range(19) == 0) item.yaw_in = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      if ($urandom_range(19) == 0) item.pitch_in = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      pick = $urandom_range(99);
      if (pick < 55) begin
         item.cmd = CMD_PUSH;
         if (pick < 5) begin
            item.stamp_ns = random_stamp();
         end else if (pick < 11) begin
            // repeat the last time to build exact ties
            item.stamp_ns = push_base;
         end else begin
            push_base = push_base + $urandom_range(skew_ns / 8 + 1, 1);
            if (push_base[STAMP_W-1:STAMP_W-2] != 2'b00) push_base = {31'd0, $urandom};
            item.stamp_ns = push_base;
         end
      end else begin
         item.cmd = CMD_QUERY;
         pick = $urandom_range(9);
         if (hist_count == 0 || pick < 2) begin
            item.stamp_ns = random_stamp();
         end else if (pick < 6) begin
            item.stamp_ns = shift_stamp(stored_stamp(), skew_delta());
         end else if (pick < 8) begin
            // halfway between two stored times makes gap ties
            mid = ({1'b0, stored_stamp()} + {1'b0, stored_stamp()}) >> 1;
            item.stamp_ns = mid[STAMP_W-1:0];
         end else begin
            item.stamp_ns = shift_stamp(push_base, skew_delta());
         end
      end
      return item;
   endfunction

   // ---------------------------------------------------------------- tests
   task automatic test_empty_history();
      query_at('0);
      query_at(STAMP_MAX);
   endtask

   task automatic test_field_extremes();
      push_sample('0, 32'h8000_0000, 32'h7FFF_FFFF);
      push_sample(STAMP_MAX, 32'h7FFF_FFFF, 32'h8000_0000);
      query_at('0);
      query_at(STAMP_MAX);
      query_at({2'b00, {(STAMP_W-2){1'b1}}});
      query_at({2'b01, {(STAMP_W-2){1'b0}}});
   endtask

   task automatic test_tie_break();
      push_sample(63'd1000, 32'h1111_1111, 32'h2222_2222);
      push_sample(63'd3000, 32'h3333_3333, 32'h4444_4444);
      query_at(63'd2000);
      push_sample(63'd3000, 32'h5555_5555, 32'hAAAA_AAAA);
      query_at(63'd3000);
      query_at(63'd2000);
   endtask

   task automatic test_skew_boundary();
      push_sample(63'd1_000_000_000_000, 32'h0001_8000, 32'hFFFE_8000);
      query_at(63'd1_000_000_000_000);
      query_at(63'd1_000_000_000_000 + SKEW_RESET);
      query_at(63'd1_000_000_000_000 - SKEW_RESET - 63'd1);
   endtask

   task automatic test_random_traffic(input logic [SKEW_W-1:0] skew, input int count,
                                      input bit quiet);
      wait_results_done(HIST_DEPTH + 8);
      write_warn_skew(skew);
      no_idle = quiet;
      for (int i = 0; i < count; i++) begin
         send_item(make_random_item());
         if (i % 120 == 119) wait_results_done(0);
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_payload    = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      no_idle        = 1'b0;
      mismatch_count = 0;
      hist_head      = 0;
      hist_count     = 0;
      skew_ns        = SKEW_RESET;
      push_base      = {31'd0, $urandom};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_history();
      test_field_extremes();
      test_tie_break();
      test_skew_boundary();
      test_random_traffic('0, 180, 1'b0);
      test_random_traffic('1, 180, 1'b0);
      test_random_traffic($urandom_range(100_000_000, 1000), 300, 1'b1);
      test_random_traffic(SKEW_RESET, 350, 1'b0);
      test_random_traffic($urandom, 370, 1'b0);

      wait_results_done(HIST_DEPTH + 8);
      if (mismatch_count == 0 && expected_matches.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
